>>> rtl/h264_nal_start_code_scanner_unit_defines.svh
// Assertion macros for the start code scanner RTL.
// Included by the top level; depends on nothing else.
`ifndef H264_NAL_START_CODE_SCANNER_UNIT_DEFINES_SVH
`define H264_NAL_START_CODE_SCANNER_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define HNSC_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the same cycle.
`define HNSC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> rtl/hnsc_pkg.sv
// Types and constants of the NAL start code scanner.
// Used by every RTL module of the block; depends on nothing.
package hnsc_pkg;

   localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
   localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;
   localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
   localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;

   localparam int unsigned FLAG_SPS = 0;
   localparam int unsigned FLAG_PPS = 1;
   localparam int unsigned FLAG_IDR = 2;

   localparam logic [7:0] START_CODE_ONE = 8'h01;
   localparam logic [2:0] MAX_HELD       = 3'd3;
   localparam logic [2:0] MAX_WORDS      = 3'd5;

   typedef struct packed {
      logic [2:0] nzero;
      logic       has_one;
      logic       has_byte;
      logic [7:0] data_byte;
      logic [2:0] flags;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

endpackage

>>> rtl/h264_nal_start_code_scanner_unit.sv
// Top level of the H.264 Annex B start code scanner.
// Depends on hnsc_pkg, hnsc_front, hnsc_queue, hnsc_back and the defines header.
//
// Usage: packet bytes enter on the req_ stream, one word per byte, with req_tlast on
// the final byte. The rsp_ stream returns every byte of each SPS or PPS unit, start
// code included, as words with tuser 0, followed by a summary word (tuser 1, tlast 1)
// that carries the packet's SPS, PPS and IDR flags. When the final byte itself yields
// five parameter-set words, the fifth carries tlast and the flags and no summary follows.
// Throughput: one byte is accepted per cycle while the command queue has room. A byte
// yields zero to five words; the back end writes one word per cycle into the output
// register while that register is empty or being taken by rsp_tready, and the queue
// of QUEUE_DEPTH commands absorbs the bursts.
// Path: the command of an accepted byte is written into the queue at the accepting edge;
// the back end then loads the byte's first word from the queue into the output register,
// where it is valid on rsp_.
// Reset: synchronous; clears the scanner state, the queue and the output register.
// Stalls: when rsp_tready is low the output word holds, the queue fills, and req_tready
// drops only once the queue is full.
`include "h264_nal_start_code_scanner_unit_defines.svh"

module h264_nal_start_code_scanner_unit
   import hnsc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   input  logic        req_tlast,   // in_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // param_byte[7:0], has_sps, has_pps, has_idr, zero pad
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // out_last
);

   q_status_type q_status;
   logic         push;
   cmd_type      push_cmd;
   logic         pop;
   cmd_type      head;

   hnsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   hnsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_status (q_status),
      .head     (head)
   );

   hnsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `HNSC_ASSERT_IMPLY(a_summary_is_last, rsp_tvalid && rsp_tuser, rsp_tlast, "summary without tlast")
   `HNSC_ASSERT_IMPLY(a_param_flagged, rsp_tvalid && !rsp_tuser, |rsp_tdata[9:8], "stray param word")
   `HNSC_ASSERT_IMPLY(a_no_push_when_full, push, !q_status.full, "command issued into a full queue")

endmodule

>>> rtl/hnsc_front.sv
// Front end: accepts bytes, tracks start codes and unit type, and issues commands.
// Depends on hnsc_pkg.
module hnsc_front
   import hnsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // in_byte[7:0]
   input  logic         req_tlast,   // in_last
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      push_cmd
);

   logic [2:0] cnt_ff, cnt_in;
   logic       pend_ff, pend_in;
   logic       param_ff, param_in;
   logic       hdr_ff, hdr_in;
   logic [2:0] flags_ff, flags_in;

   logic       accept;
   logic [4:0] nal_type;
   logic [2:0] nz_a;
   logic       one_a;
   logic       byte_a;
   logic [2:0] nz_t;
   logic       one_t;
   logic       emit;
   logic       any_byte;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign nal_type   = req_tdata[4:0] & NAL_TYPE_MASK;

   always_comb begin
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      param_in = param_ff;
      hdr_in   = hdr_ff;
      flags_in = flags_ff;
      nz_a     = 3'd0;
      one_a    = 1'b0;
      byte_a   = 1'b0;
      priority if (pend_ff) begin
         hdr_in   = 1'b1;
         param_in = (nal_type == NAL_TYPE_SPS) || (nal_type == NAL_TYPE_PPS);
         if (nal_type == NAL_TYPE_SPS) flags_in[FLAG_SPS] = 1'b1;
         if (nal_type == NAL_TYPE_PPS) flags_in[FLAG_PPS] = 1'b1;
         if (nal_type == NAL_TYPE_IDR) flags_in[FLAG_IDR] = 1'b1;
         nz_a    = cnt_ff - 3'd1;
         one_a   = 1'b1;
         byte_a  = 1'b1;
         cnt_in  = 3'd0;
         pend_in = 1'b0;
      end else if (req_tdata == 8'd0) begin
         if (cnt_ff >= MAX_HELD) begin
            nz_a   = 3'd1;
            cnt_in = MAX_HELD;
         end else begin
            cnt_in = cnt_ff + 3'd1;
         end
      end else if (req_tdata == START_CODE_ONE && cnt_ff >= 3'd2) begin
         cnt_in  = cnt_ff + 3'd1;
         pend_in = 1'b1;
      end else begin
         nz_a   = cnt_ff;
         byte_a = 1'b1;
         cnt_in = 3'd0;
      end

      nz_t  = nz_a;
      one_t = one_a;
      if (req_tlast) begin
         nz_t  = nz_a + (pend_in ? cnt_in - 3'd1 : cnt_in);
         one_t = one_a || pend_in;
      end
   end

   assign emit     = hdr_in && param_in;
   assign any_byte = (nz_t != 3'd0) || one_t || byte_a;

   always_comb begin
      push_cmd.nzero     = emit ? nz_t : 3'd0;
      push_cmd.has_one   = emit && one_t;
      push_cmd.has_byte  = emit && byte_a;
      push_cmd.data_byte = req_tdata;
      push_cmd.flags     = flags_in;
      push_cmd.last      = req_tlast;
   end

   assign push = accept && (req_tlast || (emit && any_byte));

   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         cnt_ff   <= 3'd0;
         pend_ff  <= 1'b0;
         param_ff <= 1'b0;
         hdr_ff   <= 1'b0;
         flags_ff <= 3'd0;
      end else if (accept) begin
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         param_ff <= param_in;
         hdr_ff   <= hdr_in;
         flags_ff <= flags_in;
      end
   end

endmodule

>>> rtl/hnsc_queue.sv
// Short command queue between the front and back ends of the scanner.
// Depends on hnsc_pkg.
module hnsc_queue
   import hnsc_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output q_status_type q_status,
   output cmd_type      head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.valid = (count_ff != '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && q_status.valid;
   assign head           = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries[wr_ptr_ff] <= push_cmd;
   end

endmodule

>>> rtl/hnsc_back.sv
// Back end: expands each command into output register words, one per cycle unless stalled.
// Depends on hnsc_pkg.
module hnsc_back
   import hnsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  cmd_type      head,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // param_byte[7:0], has_sps, has_pps, has_idr, zero pad
   output logic         rsp_tuser,   // kind
   output logic         rsp_tlast    // out_last
);

   logic [2:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [2:0]  nbytes;
   logic [2:0]  total;
   logic        advance;
   logic        at_end;
   logic [7:0]  word_byte;
   logic        word_kind;

   assign nbytes  = head.nzero + 3'(head.has_one) + 3'(head.has_byte);
   assign total   = nbytes + 3'(head.last && (nbytes != MAX_WORDS));
   assign advance = q_status.valid && (!rsp_valid_ff || rsp_tready);
   assign at_end  = (pos_ff == total - 3'd1);
   assign pop     = advance && at_end;

   always_comb begin
      word_kind = 1'b0;
      priority if (pos_ff < head.nzero) begin
         word_byte = 8'd0;
      end else if (pos_ff == head.nzero && head.has_one) begin
         word_byte = START_CODE_ONE;
      end else if (pos_ff < nbytes) begin
         word_byte = head.data_byte;
      end else begin
         word_byte = 8'd0;
         word_kind = 1'b1;
      end

      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         pos_in       = at_end ? 3'd0 : pos_ff + 3'd1;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, head.flags[FLAG_IDR], head.flags[FLAG_PPS],
                         head.flags[FLAG_SPS], word_byte};
         rsp_kind_in  = word_kind;
         rsp_last_in  = head.last && at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> sim/tb_h264_nal_start_code_scanner_unit.sv
// Self-checking testbench for the H.264 Annex B start code scanner.
// It streams whole packets and predicts every parameter-set word and summary.
// It depends on hnsc_pkg and h264_nal_start_code_scanner_unit.
`timescale 1ns / 1ps

module tb_h264_nal_start_code_scanner_unit;
   import hnsc_pkg::*;

   localparam logic KIND_PARAM   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;
   localparam int RANDOM_BYTES = 200;
   localparam int HOLD_AT      = 40;
   localparam int HOLD_CYCLES  = 80;
   localparam int CALM_FROM    = 90;
   localparam int CALM_TO      = 140;
   localparam int PAUSE_AT     = 160;

   typedef struct packed {
      logic       kind;
      logic [7:0] param_byte;
      logic [2:0] flags;
      logic       last;
   } scan_word_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } packet_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // in_byte[7:0]
   logic        req_tlast = 1'b0;    // in_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // param_byte[7:0], has_sps, has_pps, has_idr, zero pad
   logic        rsp_tuser;           // kind
   logic        rsp_tlast;           // out_last

   h264_nal_start_code_scanner_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   packet_byte_type bytes_to_send[$];
   logic [7:0]      pkt[$];
   scan_word_type   words_due[$];
   int              total_bytes;
   int              accepted_count = 0;
   int              offered_count = 0;
   int              hold_left = 0;
   bit              hold_done = 1'b0;
   int              error_count = 0;
   packet_byte_type item_out;
   scan_word_type   want;
   logic            calm;

   assign calm = (accepted_count >= CALM_FROM) && (accepted_count < CALM_TO);

   // Scanner state as the block keeps it between bytes of one packet.
   logic [7:0]    held [0:3];
   logic [2:0]    held_count;
   logic [1:0]    zero_run;
   logic          code_pending;
   logic          in_param_unit;
   logic          unit_open;
   logic [2:0]    seen;
   scan_word_type step_words [0:4];
   int            step_count;

   task automatic clear_scanner();
      for (int i = 0; i < 4; i++) held[i] = 8'h00;
      held_count    = '0;
      zero_run      = '0;
      code_pending  = 1'b0;
      in_param_unit = 1'b0;
      unit_open     = 1'b0;
      seen          = '0;
   endtask

   task automatic put_word(input logic kind, input logic [7:0] b, input logic last);
      if (step_count < MAX_WORDS) begin
         step_words[step_count] = '{kind, b, seen, last};
         step_count++;
      end
   endtask

   task automatic unit_word(input logic [7:0] b);
      if (unit_open && in_param_unit) put_word(KIND_PARAM, b, 1'b0);
   endtask

   task automatic flush_held();
      for (int i = 0; i < held_count; i++) unit_word(held[i]);
      held_count   = '0;
      zero_run     = '0;
      code_pending = 1'b0;
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic last);
      logic [4:0] nal_type;
      step_count = 0;
      nal_type = b[4:0] & NAL_TYPE_MASK;
      if (code_pending) begin
         unit_open = 1'b1;
         in_param_unit = (nal_type == NAL_TYPE_SPS) || (nal_type == NAL_TYPE_PPS);
         if (nal_type == NAL_TYPE_SPS) seen[FLAG_SPS] = 1'b1;
         if (nal_type == NAL_TYPE_PPS) seen[FLAG_PPS] = 1'b1;
         if (nal_type == NAL_TYPE_IDR) seen[FLAG_IDR] = 1'b1;
         flush_held();
         unit_word(b);
      end else if (b == 8'h00) begin
         if (zero_run >= 2'd3 || held_count >= MAX_HELD) begin
            // A fourth zero pushes the oldest held zero into the open unit.
            unit_word(held[0]);
            held[0] = held[1];
            held[1] = held[2];
            held[2] = 8'h00;
            held_count = MAX_HELD;
            zero_run = 2'd3;
         end else begin
            held[held_count[1:0]] = 8'h00;
            held_count++;
            zero_run++;
         end
      end else if (b == START_CODE_ONE && zero_run >= 2'd2 && held_count < 3'd4) begin
         held[held_count[1:0]] = START_CODE_ONE;
         held_count++;
         code_pending = 1'b1;
      end else begin
         flush_held();
         unit_word(b);
      end
      if (last) begin
         flush_held();
         if (step_count < MAX_WORDS) put_word(KIND_SUMMARY, 8'h00, 1'b1);
         else step_words[step_count - 1].last = 1'b1;
         clear_scanner();
      end
      for (int i = 0; i < step_count; i++) words_due.push_back(step_words[i]);
   endtask

   task automatic commit_packet();
      for (int i = 0; i < pkt.size(); i++)
         bytes_to_send.push_back('{pkt[i], i == pkt.size() - 1});
      pkt.delete();
   endtask

   function automatic logic [7:0] pick_byte();
      int roll;
      roll = $urandom_range(9);
      if (roll < 3) return 8'h00;
      if (roll == 3) return START_CODE_ONE;
      return 8'($urandom_range(255));
   endfunction

   task automatic build_random_packet();
      int units;
      int zeros;
      int roll;
      logic [4:0] nal_type;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(12, 1)) pkt.push_back(pick_byte());
      end else begin
         if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) pkt.push_back(pick_byte());
         units = $urandom_range(3, 1);
         for (int u = 0; u < units; u++) begin
            zeros = ($urandom_range(7) == 0) ? 5 : $urandom_range(4, 2);
            repeat (zeros) pkt.push_back(8'h00);
            pkt.push_back(START_CODE_ONE);
            if (u == units - 1 && $urandom_range(7) == 0) break;
            roll = $urandom_range(9);
            if (roll < 3) nal_type = NAL_TYPE_SPS;
            else if (roll < 6) nal_type = NAL_TYPE_PPS;
            else if (roll < 8) nal_type = NAL_TYPE_IDR;
            else nal_type = 5'($urandom_range(31));
            pkt.push_back({3'($urandom_range(7)), nal_type});
            repeat ($urandom_range(6)) pkt.push_back(pick_byte());
         end
      end
      commit_packet();
   endtask

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      clear_scanner();
      // Leading bytes dropped, SPS, a fourth zero, PPS, and a start code that ends the packet.
      pkt = '{8'hAA, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
              8'hE8, 8'h00, 8'h00, 8'h01};
      commit_packet();
      // The final byte opens an SPS after a four-byte code.
      pkt = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67};
      commit_packet();
      // IDR, then a header byte that looks like code data, then a full-range byte.
      pkt = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01, 8'h01, 8'hFF};
      commit_packet();
      pkt = '{8'h00};
      commit_packet();
      while (bytes_to_send.size() < 29 + RANDOM_BYTES) build_random_packet();
      total_bytes = bytes_to_send.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != total_bytes) @(posedge clock);
      while (words_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0 && words_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            scan_byte(req_tdata, req_tlast);
            accepted_count <= accepted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (bytes_to_send.size() != 0
                && !(offered_count == PAUSE_AT && words_due.size() != 0)
                && (calm || $urandom_range(99) >= 8)) begin
               item_out = bytes_to_send.pop_front();
               req_tvalid    <= 1'b1;
               req_tdata     <= item_out.data;
               req_tlast     <= item_out.last;
               offered_count <= offered_count + 1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // The receiver stops once for a long stretch so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || $urandom_range(99) >= 8;
      end
   end

   task automatic check_field(input string name, input logic [7:0] expected,
                              input logic [7:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (words_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual tdata %h tuser %b tlast %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = words_due.pop_front();
            check_field("kind", 8'(want.kind), 8'(rsp_tuser));
            check_field("param_byte", want.param_byte, rsp_tdata[7:0]);
            check_field("has_sps", 8'(want.flags[FLAG_SPS]), 8'(rsp_tdata[8 + FLAG_SPS]));
            check_field("has_pps", 8'(want.flags[FLAG_PPS]), 8'(rsp_tdata[8 + FLAG_PPS]));
            check_field("has_idr", 8'(want.flags[FLAG_IDR]), 8'(rsp_tdata[8 + FLAG_IDR]));
            check_field("out_last", 8'(want.last), 8'(rsp_tlast));
         end
      end
   end

endmodule
